// File: sv/dnsqf_pkg.sv
package dnsqf_pkg;

	localparam int MAX_LABEL_DEF = 32;
	localparam int HDR_LEN = 12;
	localparam int TRL_LEN = 5;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] BYTE_ONE = 8'h01;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	localparam logic [3:0] HDR_ID_HI = 4'd0;
	localparam logic [3:0] HDR_ID_LO = 4'd1;
	localparam logic [3:0] HDR_FLAGS = 4'd2;
	localparam logic [3:0] HDR_QDCOUNT_LO = 4'd5;

	localparam logic [2:0] TRL_TYPE_LO = 3'd2;
	localparam logic [2:0] TRL_CLASS_LO = 3'd4;

	typedef struct packed {
		logic [7:0] name_char;
		logic name_end;
	} name_item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic packet_end;
		logic label_overflow;
	} pkt_item_t;

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid);
		logic [7:0] b;
		b = BYTE_ZERO;
		case (idx) inside
			HDR_ID_HI: b = qid[15:8];
			HDR_ID_LO: b = qid[7:0];
			HDR_FLAGS, HDR_QDCOUNT_LO: b = BYTE_ONE;
			default: b = BYTE_ZERO;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] trl_byte(input logic [2:0] idx);
		logic [7:0] b;
		b = BYTE_ZERO;
		case (idx) inside
			TRL_TYPE_LO, TRL_CLASS_LO: b = BYTE_ONE;
			default: b = BYTE_ZERO;
		endcase
		return b;
	endfunction

endpackage

// File: sv/dnsqf_ram.sv
module dnsqf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/dns_query_framer.sv
// Channel  Direction  Handshake                Payload
// name     in         name_valid / name_ready  name_item (name_char, name_end)
// pkt      out        pkt_valid / pkt_ready    pkt_item (packet_byte, packet_end, label_overflow)
// cfg      in         cfg_we                   cfg_wdata (query_id)
//
// A character that opens or closes no label is taken with no output. Otherwise the
// block emits 12 header bytes if it opens a message, then, if it closes a label,
// one length byte, the label bytes read from the label RAM (its read primed
// before each nonempty label), a zero length byte after a final dot, and on the
// last character the trailer. The next character is taken once the last byte of
// the transaction sits in the output register. Reset clears all control state;
// the label RAM needs no clearing. A stalled output holds the sequencer in place.
module dns_query_framer #(
	parameter int MAX_LABEL = dnsqf_pkg::MAX_LABEL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic name_valid,
	output logic name_ready,
	input  dnsqf_pkg::name_item_t name_item,
	output logic pkt_valid,
	input  logic pkt_ready,
	output dnsqf_pkg::pkt_item_t pkt_item,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_LABEL + 1);
	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int IW = (CW > 4) ? CW : 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR = 3'd1;
	localparam logic [2:0] ST_LEN = 3'd2;
	localparam logic [2:0] ST_LBL = 3'd3;
	localparam logic [2:0] ST_ZLEN = 3'd4;
	localparam logic [2:0] ST_TRL = 3'd5;

	logic [2:0] state_q;
	logic [IW-1:0] cnt_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] count_q;
	logic in_pkt_q;
	logic ovf_q;
	logic flag_q;
	logic lbl_q;
	logic zlen_q;
	logic trl_q;
	logic rd_ok_q;
	logic [15:0] qid_q;
	logic out_valid_q;
	dnsqf_pkg::pkt_item_t out_q;

	logic accept;
	logic is_dot;
	logic full;
	logic store;
	logic closes;
	logic [CW-1:0] new_count;
	logic new_flag;

	logic out_free;
	logic load;
	logic seg_last;
	logic [2:0] next_state;
	logic [7:0] emit_byte;
	logic emit_end;
	logic ram_re;
	logic [IW-1:0] rd_idx;
	logic [7:0] ram_rdata;

	assign name_ready = (state_q == ST_IDLE);
	assign accept = name_valid && name_ready;
	assign is_dot = (name_item.name_char == dnsqf_pkg::DOT_CHAR);
	assign full = (count_q >= CW'(MAX_LABEL));
	assign store = accept && !is_dot && !full;
	assign new_count = count_q + CW'(!is_dot && !full);
	assign new_flag = is_dot ? ovf_q : (ovf_q | full);
	assign closes = is_dot || name_item.name_end;

	assign out_free = !out_valid_q || pkt_ready;

	always_comb begin
		load = 1'b0;
		seg_last = 1'b0;
		emit_byte = dnsqf_pkg::BYTE_ZERO;
		emit_end = 1'b0;
		next_state = ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				load = 1'b0;
			end
			ST_HDR: begin
				load = out_free;
				emit_byte = dnsqf_pkg::hdr_byte(cnt_q[3:0], qid_q);
				seg_last = (cnt_q == IW'(dnsqf_pkg::HDR_LEN - 1));
				next_state = lbl_q ? ST_LEN : ST_IDLE;
			end
			ST_LEN: begin
				load = out_free;
				emit_byte = 8'(len_q);
				seg_last = 1'b1;
				if (len_q != '0) begin
					next_state = ST_LBL;
				end else if (zlen_q) begin
					next_state = ST_ZLEN;
				end else if (trl_q) begin
					next_state = ST_TRL;
				end else begin
					next_state = ST_IDLE;
				end
			end
			ST_LBL: begin
				load = out_free && rd_ok_q;
				emit_byte = ram_rdata;
				seg_last = (cnt_q == IW'(len_q) - IW'(1));
				if (zlen_q) begin
					next_state = ST_ZLEN;
				end else if (trl_q) begin
					next_state = ST_TRL;
				end else begin
					next_state = ST_IDLE;
				end
			end
			ST_ZLEN: begin
				load = out_free;
				seg_last = 1'b1;
				next_state = ST_TRL;
			end
			ST_TRL: begin
				load = out_free;
				emit_byte = dnsqf_pkg::trl_byte(cnt_q[2:0]);
				seg_last = (cnt_q == IW'(dnsqf_pkg::TRL_LEN - 1));
				emit_end = seg_last;
				next_state = ST_IDLE;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == ST_LBL) && (!rd_ok_q || load);
	assign rd_idx = rd_ok_q ? (cnt_q + IW'(1)) : cnt_q;

	dnsqf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LABEL),
		.AW(AW)
	) u_label_ram (
		.clk(clk),
		.we(store),
		.waddr(count_q[AW-1:0]),
		.wdata(name_item.name_char),
		.re(ram_re),
		.raddr(rd_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			len_q <= '0;
			count_q <= '0;
			in_pkt_q <= 1'b0;
			ovf_q <= 1'b0;
			flag_q <= 1'b0;
			lbl_q <= 1'b0;
			zlen_q <= 1'b0;
			trl_q <= 1'b0;
			rd_ok_q <= 1'b0;
			qid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				qid_q <= cfg_wdata;
			end
			if (accept) begin
				flag_q <= new_flag;
				len_q <= is_dot ? count_q : new_count;
				lbl_q <= closes;
				zlen_q <= is_dot && name_item.name_end;
				trl_q <= name_item.name_end;
				count_q <= closes ? '0 : new_count;
				ovf_q <= closes ? 1'b0 : new_flag;
				in_pkt_q <= !name_item.name_end;
				cnt_q <= '0;
				if (!in_pkt_q) begin
					state_q <= ST_HDR;
				end else if (closes) begin
					state_q <= ST_LEN;
				end else begin
					state_q <= ST_IDLE;
				end
			end else if (load) begin
				if (seg_last) begin
					cnt_q <= '0;
					state_q <= next_state;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
			rd_ok_q <= (state_q == ST_LBL) && !(load && seg_last);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pkt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.packet_byte <= emit_byte;
			out_q.packet_end <= emit_end;
			out_q.label_overflow <= flag_q;
		end
	end

	assign pkt_valid = out_valid_q;
	assign pkt_item = out_q;

	a_end_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emit_end) |=> (state_q == ST_IDLE))
		else $error("Sequencer did not return to idle after the final byte.");

	a_label_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LBL) |-> (len_q != '0))
		else $error("Label byte phase entered with an empty label.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LABEL))
		else $error("Label count exceeds the label limit.");

	a_end_clears_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && name_item.name_end) |=> (!in_pkt_q && (count_q == '0) && !ovf_q))
		else $error("Packet state not cleared after the final character.");

endmodule

// File: verif/dns_query_framer_tb.sv
`timescale 1ns / 1ps

module dns_query_framer_tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NUM_PHASES = 5;
	localparam int RANDOM_CHARS_PER_PHASE = 31;
	localparam int LBL_AW = $clog2(dnsqf_pkg::MAX_LABEL_DEF);
	localparam int IDLE_PLAN [NUM_PHASES] = '{0, 83, 0, 31, 0};
	localparam int STALL_PLAN [NUM_PHASES] = '{0, 0, 83, 31, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic name_valid = 1'b0;
	logic name_ready;
	dnsqf_pkg::name_item_t name_item = '0;
	logic pkt_valid;
	logic pkt_ready = 1'b0;
	dnsqf_pkg::pkt_item_t pkt_item;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	dnsqf_pkg::name_item_t pending_chars[$];
	dnsqf_pkg::pkt_item_t expected_bytes[$];
	dnsqf_pkg::pkt_item_t step_bytes[$];
	logic [15:0] qid_plan [NUM_PHASES];

	logic [7:0] label_mem [dnsqf_pkg::MAX_LABEL_DEF];
	logic [5:0] label_len = '0;
	logic msg_open = 1'b0;
	logic label_dropped = 1'b0;
	logic [15:0] query_id_model = 16'h0000;

	int idle_pct = 0;
	int stall_pct = 0;
	int chars_pushed = 0;
	int chars_accepted = 0;
	int names_done = 0;
	int bytes_checked = 0;
	int overflow_labels = 0;
	int long_labels = 0;
	int errors = 0;
	int idle_cycles = 0;

	dns_query_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.name_valid(name_valid),
		.name_ready(name_ready),
		.name_item(name_item),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt_item(pkt_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function void append_label();
		step_bytes.push_back(dnsqf_pkg::pkt_item_t'{{2'b00, label_len}, 1'b0, 1'b0});
		for (int i = 0; i < label_len; i++) begin
			step_bytes.push_back(dnsqf_pkg::pkt_item_t'{label_mem[i], 1'b0, 1'b0});
		end
	endfunction

	function void predict_query_bytes(input dnsqf_pkg::name_item_t it);
		logic flag;
		logic [7:0] b;
		step_bytes.delete();
		if (!msg_open) begin
			for (int k = 0; k < dnsqf_pkg::HDR_LEN; k++) begin
				case (k) inside
					dnsqf_pkg::HDR_ID_HI: b = query_id_model[15:8];
					dnsqf_pkg::HDR_ID_LO: b = query_id_model[7:0];
					dnsqf_pkg::HDR_FLAGS, dnsqf_pkg::HDR_QDCOUNT_LO: b = dnsqf_pkg::BYTE_ONE;
					default: b = dnsqf_pkg::BYTE_ZERO;
				endcase
				step_bytes.push_back(dnsqf_pkg::pkt_item_t'{b, 1'b0, 1'b0});
			end
			msg_open = 1'b1;
		end
		if (it.name_char == dnsqf_pkg::DOT_CHAR) begin
			flag = label_dropped;
			append_label();
			label_len = '0;
			label_dropped = 1'b0;
		end else begin
			if (label_len < dnsqf_pkg::MAX_LABEL_DEF) begin
				label_mem[label_len[LBL_AW-1:0]] = it.name_char;
				label_len = label_len + 6'd1;
			end else begin
				label_dropped = 1'b1;
			end
			flag = label_dropped;
		end
		if (flag && (it.name_char == dnsqf_pkg::DOT_CHAR || it.name_end)) begin
			overflow_labels++;
		end
		if (it.name_end) begin
			append_label();
			for (int k = 0; k < dnsqf_pkg::TRL_LEN; k++) begin
				case (k) inside
					dnsqf_pkg::TRL_TYPE_LO, dnsqf_pkg::TRL_CLASS_LO: b = dnsqf_pkg::BYTE_ONE;
					default: b = dnsqf_pkg::BYTE_ZERO;
				endcase
				step_bytes.push_back(dnsqf_pkg::pkt_item_t'{b, k == dnsqf_pkg::TRL_LEN - 1,
					1'b0});
			end
			msg_open = 1'b0;
			label_len = '0;
			label_dropped = 1'b0;
			names_done++;
		end
		foreach (step_bytes[i]) begin
			step_bytes[i].label_overflow = flag;
			expected_bytes.push_back(step_bytes[i]);
		end
	endfunction

	task report_mismatch(input string what);
		errors++;
		$display("ERROR %0t: %s", $time, what);
	endtask

	task push_char(input logic [7:0] c, input logic last);
		pending_chars.push_back(dnsqf_pkg::name_item_t'{c, last});
		chars_pushed++;
	endtask

	task drain_all();
		while (chars_accepted != chars_pushed || expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task run_random_names(input int n_chars);
		int target;
		int n_labels;
		int len;
		int r;
		logic [7:0] c;
		dnsqf_pkg::name_item_t chars[$];
		target = chars_pushed + n_chars;
		while (chars_pushed < target) begin
			if ($urandom_range(7) == 0) begin
				drain_all();
			end
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 6)) begin
					push_char(8'($urandom_range(255)), $urandom_range(3) == 0);
				end
			end else begin
				chars.delete();
				n_labels = $urandom_range(1, 4);
				for (int l = 0; l < n_labels; l++) begin
					if (l > 0) begin
						chars.push_back(dnsqf_pkg::name_item_t'{dnsqf_pkg::DOT_CHAR, 1'b0});
					end
					r = $urandom_range(99);
					if (long_labels == 0 || r < 6) begin
						len = $urandom_range(dnsqf_pkg::MAX_LABEL_DEF - 2,
							dnsqf_pkg::MAX_LABEL_DEF + 8);
						long_labels++;
					end else if (r < 12) begin
						len = 0;
					end else begin
						len = $urandom_range(1, 6);
					end
					repeat (len) begin
						c = 8'($urandom_range(255));
						if (c == dnsqf_pkg::DOT_CHAR) begin
							c = c + 8'd1;
						end
						chars.push_back(dnsqf_pkg::name_item_t'{c, 1'b0});
					end
				end
				if (chars.size() == 0) begin
					chars.push_back(dnsqf_pkg::name_item_t'{dnsqf_pkg::DOT_CHAR, 1'b0});
				end
				// Now and then the name runs on into the next one.
				chars[chars.size() - 1].name_end = ($urandom_range(9) != 0);
				foreach (chars[i]) begin
					if (chars_pushed < target) begin
						push_char(chars[i].name_char, chars[i].name_end);
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_valid <= 1'b0;
			pkt_ready <= 1'b0;
		end else begin
			pkt_ready <= ($urandom_range(99) >= stall_pct);
			if (!name_valid || name_ready) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
					name_item <= pending_chars.pop_front();
					name_valid <= 1'b1;
				end else begin
					name_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		dnsqf_pkg::pkt_item_t exp_byte;
		if (arst_n) begin
			if (name_valid && name_ready) begin
				predict_query_bytes(name_item);
				chars_accepted++;
			end
			if (pkt_valid && pkt_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", pkt_item.packet_byte));
				end else begin
					exp_byte = expected_bytes.pop_front();
					if (pkt_item.packet_byte !== exp_byte.packet_byte) begin
						report_mismatch($sformatf("packet_byte expected %02h, got %02h",
							exp_byte.packet_byte, pkt_item.packet_byte));
					end
					if (pkt_item.packet_end !== exp_byte.packet_end) begin
						report_mismatch($sformatf("packet_end expected %b, got %b",
							exp_byte.packet_end, pkt_item.packet_end));
					end
					if (pkt_item.label_overflow !== exp_byte.label_overflow) begin
						report_mismatch($sformatf("label_overflow expected %b, got %b",
							exp_byte.label_overflow, pkt_item.label_overflow));
					end
					bytes_checked++;
				end
			end
			if ((name_valid && name_ready) || (pkt_valid && pkt_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d cycles without a transaction.", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		qid_plan[0] = 16'hFFFF;
		qid_plan[1] = 16'h0000;
		qid_plan[2] = 16'($urandom_range(16'hFFFF));
		qid_plan[3] = 16'($urandom_range(16'hFFFF));
		qid_plan[4] = 16'h8001;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_all();
			cfg_we <= 1'b1;
			cfg_wdata <= qid_plan[p];
			query_id_model = qid_plan[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			idle_pct = IDLE_PLAN[p];
			stall_pct = STALL_PLAN[p];
			if (p == 0) begin
				push_char(8'h00, 1'b1);
				push_char(dnsqf_pkg::DOT_CHAR, 1'b1);
				push_char(dnsqf_pkg::DOT_CHAR, 1'b0);
				push_char("a", 1'b0);
				push_char(dnsqf_pkg::DOT_CHAR, 1'b0);
				push_char(dnsqf_pkg::DOT_CHAR, 1'b0);
				push_char("b", 1'b1);
				push_char(8'hFF, 1'b0);
				push_char(8'h7F, 1'b0);
				push_char(dnsqf_pkg::DOT_CHAR, 1'b1);
				push_char(8'h80, 1'b0);
				push_char(8'h2D, 1'b0);
				push_char(8'h2F, 1'b1);
			end
			run_random_names(RANDOM_CHARS_PER_PHASE);
		end
		drain_all();
		$display("Checked %0d message bytes from %0d characters in %0d names.",
			bytes_checked, chars_accepted, names_done);
		$display("%0d labels dropped characters; query ids 0000, FFFF and others were used.",
			overflow_labels);
		$display("Profiles covered: no idling, sender gaps, receiver stalls and both.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
